// File: hdl/cfdl_pkg.sv
// Shared types, constants and tables of the contact focal delay law block.
package cfdl_pkg;

  // Store size and counter widths
  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  // Fixed-point constants
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic [19:0] FOCAL_MAX   = 20'd1048575;
  localparam logic [20:0] DIST_MAX    = 21'd2097151;
  localparam logic [23:0] DELAY_MAX   = 24'd16777215;
  localparam logic [21:0] NS_SCALE    = 22'd1000;
  localparam logic signed [15:0] STEER_LIM = 16'sd9000;
  localparam logic signed [15:0] SKEW_LIM  = 16'sd18000;

  // Shared divider widths
  localparam int NUM_W = 49;
  localparam int DEN_W = 31;

  // Register map
  typedef enum logic [2:0] {
    REG_STEER = 3'd0,
    REG_SKEW  = 3'd1,
    REG_FOCAL = 3'd2,
    REG_DEPTH = 3'd3,
    REG_VEL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] steer_angle;
    logic signed [15:0] skew_angle;
    logic [18:0]        focal_length;
    logic               focus_is_depth;
    logic [14:0]        plate_velocity;
  } cfg_t;

  typedef struct packed {
    logic signed [19:0] elem_x;
    logic signed [19:0] elem_y;
    logic signed [19:0] elem_z;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [23:0] element_delay;
    logic        delay_saturated;
    logic        last_delay;
  } out_item_t;

  // Queued item: element plus the front's classification
  typedef struct packed {
    in_item_t item;
    logic     first;
    logic     end_law;
  } q_item_t;

  // Arctangent table, 0.01 degree / 65536 units
  function automatic logic [28:0] atan_f(input logic [4:0] i);
    logic [28:0] v;
    case (i)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183346;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/contact_focal_delay_law_top.sv
// Top level: register port, front end and back end of the focal law block.
//
//  port group   direction  handshake                  payload
//  start/busy   in         start & !busy              in_data (in_item_t)
//  out_*        out        out_strobe, one cycle      out_data (out_item_t)
//  APB          in/out     psel & penable & pwrite    pwdata / prdata
//
// First element of a law: two CORDIC runs, four focal multiplies, then the distance
// work, plus a divider run for a depth focal length with a positive steering cosine.
// Each later element is paced by the 23-step square root.
// Each delay is paced by the 49-step divider.
// Synchronous active-low reset; the queue takes two items while the back works.
// The receiver cannot stall: out_strobe is high for one cycle only per delay.
module contact_focal_delay_law_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cfdl_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output cfdl_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfdl_pkg::cfg_t    cfg_r;
  logic              cfg_we;
  logic [2:0]        cfg_idx;
  logic              pop, q_valid;
  cfdl_pkg::q_item_t q_item;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_angle    <= '0;
      cfg_r.skew_angle     <= '0;
      cfg_r.focal_length   <= 19'd50000;
      cfg_r.focus_is_depth <= 1'b0;
      cfg_r.plate_velocity <= 15'd5940;
    end else if (cfg_we) begin
      case (cfg_idx)
        cfdl_pkg::REG_STEER: cfg_r.steer_angle    <= pwdata[14:0];
        cfdl_pkg::REG_SKEW:  cfg_r.skew_angle     <= pwdata[15:0];
        cfdl_pkg::REG_FOCAL: cfg_r.focal_length   <= pwdata[18:0];
        cfdl_pkg::REG_DEPTH: cfg_r.focus_is_depth <= pwdata[0];
        cfdl_pkg::REG_VEL:   cfg_r.plate_velocity <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_idx)
      cfdl_pkg::REG_STEER: prdata = {17'b0, cfg_r.steer_angle};
      cfdl_pkg::REG_SKEW:  prdata = {16'b0, cfg_r.skew_angle};
      cfdl_pkg::REG_FOCAL: prdata = {13'b0, cfg_r.focal_length};
      cfdl_pkg::REG_DEPTH: prdata = {31'b0, cfg_r.focus_is_depth};
      cfdl_pkg::REG_VEL:   prdata = {17'b0, cfg_r.plate_velocity};
      default:             prdata = '0;
    endcase
  end

  cfdl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  cfdl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// File: hdl/cfdl_front.sv
// Front end: accepts element items, marks first/last of a law, queues them.
module cfdl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cfdl_pkg::in_item_t in_data,
  output logic              busy,
  input  logic              pop,
  output logic              q_valid,
  output cfdl_pkg::q_item_t q_item
);

  logic [cfdl_pkg::IDX_W-1:0] fcnt_r;
  cfdl_pkg::q_item_t          q_mem_r [2];
  logic                       wp_r, rp_r;
  logic [1:0]                 qn_r;
  logic                       push;
  cfdl_pkg::q_item_t          ent;

  assign busy    = (qn_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (qn_r != 2'd0);
  assign q_item  = q_mem_r[rp_r];

  // Classify: first element of a law, and the element that ends it
  always_comb begin
    ent.item    = in_data;
    ent.first   = (fcnt_r == '0);
    ent.end_law = in_data.last_element ||
                  (fcnt_r == cfdl_pkg::IDX_W'(cfdl_pkg::MAX_ELEMENTS - 1));
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= ent;
    end
  end

  // Queue pointers and law position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      qn_r   <= 2'd0;
    end else begin
      if (push) begin
        wp_r   <= !wp_r;
        fcnt_r <= ent.end_law ? '0 : fcnt_r + 1'b1;
      end
      if (pop && q_valid) begin
        rp_r <= !rp_r;
      end
      qn_r <= qn_r + {1'b0, push} - {1'b0, pop && q_valid};
    end
  end

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (qn_r != 2'd3))
    else $error("queue fill out of range");
`endif

endmodule

// File: hdl/cfdl_cordic.sv
// Iterative CORDIC rotator: cosine and sine of an angle in 0.01 degree.
module cfdl_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cst_t;

  cst_t               st_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [4:0]         i_r;
  logic               flip_r;
  logic               done_r;
  logic signed [31:0] cos_r, sin_r;

  logic signed [16:0] a17, af;
  logic               fl;
  logic signed [33:0] dxs, dys, xc, yc;
  logic signed [32:0] at;

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

  // Fold beyond +-90 degrees
  always_comb begin
    a17 = {angle[15], angle};
    af  = a17;
    fl  = 1'b0;
    if (a17 > 17'sd9000) begin
      af = a17 - 17'sd18000;
      fl = 1'b1;
    end else if (a17 < -17'sd9000) begin
      af = a17 + 17'sd18000;
      fl = 1'b1;
    end
  end

  // One rotation step
  always_comb begin
    dxs = y_r >>> i_r;
    dys = x_r >>> i_r;
    at  = $signed({4'b0, cfdl_pkg::atan_f(i_r)});
    xc  = x_r;
    yc  = y_r;
    if (x_r > cfdl_pkg::Q30_ONE)  xc = cfdl_pkg::Q30_ONE;
    if (x_r < -cfdl_pkg::Q30_ONE) xc = -cfdl_pkg::Q30_ONE;
    if (y_r > cfdl_pkg::Q30_ONE)  yc = cfdl_pkg::Q30_ONE;
    if (y_r < -cfdl_pkg::Q30_ONE) yc = -cfdl_pkg::Q30_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        C_IDLE: begin
          if (start) begin
            x_r    <= cfdl_pkg::CORDIC_GAIN;
            y_r    <= '0;
            z_r    <= {af, 16'b0};
            flip_r <= fl;
            i_r    <= '0;
            st_r   <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_r[32]) begin
            x_r <= x_r - dxs;
            y_r <= y_r + dys;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dxs;
            y_r <= y_r - dys;
            z_r <= z_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(cfdl_pkg::CORDIC_STEPS - 1)) begin
            st_r <= C_FIN;
          end
        end
        C_FIN: begin
          cos_r  <= flip_r ? -xc[31:0] : xc[31:0];
          sin_r  <= flip_r ? -yc[31:0] : yc[31:0];
          done_r <= 1'b1;
          st_r   <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/cfdl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module cfdl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cfdl_pkg::NUM_W-1:0]   num,
  input  logic [cfdl_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [cfdl_pkg::NUM_W-1:0]   quo
);

  logic                       busy_r, done_r;
  logic [cfdl_pkg::DEN_W-1:0] rem_r, den_r;
  logic [cfdl_pkg::NUM_W-1:0] quo_r;
  logic [5:0]                 cnt_r;
  logic [cfdl_pkg::DEN_W:0]   trial;
  logic                       ge;

  assign done  = done_r;
  assign quo   = quo_r;
  assign trial = {rem_r, quo_r[cfdl_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? cfdl_pkg::DEN_W'(trial - {1'b0, den_r})
                    : trial[cfdl_pkg::DEN_W-1:0];
        quo_r <= {quo_r[cfdl_pkg::NUM_W-2:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(cfdl_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

// File: hdl/cfdl_back.sv
// Back end: focal point, element distances, distance store and delay output.
module cfdl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfdl_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  cfdl_pkg::q_item_t  q_item,
  output logic               pop,
  output logic               out_strobe,
  output cfdl_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_COS_A, S_WAIT_A, S_COS_O, S_WAIT_O, S_FE, S_FE_WAIT,
    S_MUL, S_MUL_WB, S_SQRT, S_STORE, S_RD, S_DIV_WAIT
  } st_t;

  typedef enum logic [2:0] {
    M_FX, M_T, M_FY, M_FZ, M_DX, M_DY, M_DZ, M_DLY
  } mstep_t;

  st_t                st_r;
  mstep_t             mstep_r;
  logic signed [19:0] ex_r, ey_r, ez_r;
  logic               end_r;
  logic signed [31:0] ca_r, sa_r, co_r, so_r;
  logic [19:0]        fe_r;
  logic signed [20:0] t_r, fpx_r, fpy_r, fpz_r;
  logic signed [53:0] prod_r;
  logic [44:0]        acc_r;
  logic [45:0]        sqn_r, sqr_r, sqb_r;
  logic [4:0]         sqi_r;
  logic [cfdl_pkg::CNT_W-1:0] cnt_r, k_r;
  logic [20:0]        max_r;
  logic               out_vld_r;
  cfdl_pkg::out_item_t out_r;

  // Distance store
  logic [20:0] dmem [cfdl_pkg::MAX_ELEMENTS];
  logic [20:0] rd_r;
  logic        we;
  logic [20:0] dist_w;

  // Shared units
  logic               c_start, c_done;
  logic signed [15:0] c_angle;
  logic signed [31:0] c_cos, c_sin;
  logic               d_start, d_done;
  logic [cfdl_pkg::NUM_W-1:0] d_num, d_quo;
  logic [cfdl_pkg::DEN_W-1:0] d_den;

  logic signed [15:0] steer16, steer_c, skew_c;
  logic signed [21:0] dx, dy, dz;
  logic signed [31:0] ma;
  logic signed [21:0] mb;
  logic signed [53:0] rsum;
  logic signed [23:0] rnd;
  logic signed [20:0] rclamp;
  logic [45:0]        sq_sum;
  logic               sq_ge;
  logic [14:0]        vel;
  logic               sat;

  assign pop        = (st_r == S_IDLE) && q_valid;
  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  // Angle clamps
  always_comb begin
    steer16 = {cfg.steer_angle[14], cfg.steer_angle};
    steer_c = steer16;
    if (steer16 > cfdl_pkg::STEER_LIM)  steer_c = cfdl_pkg::STEER_LIM;
    if (steer16 < -cfdl_pkg::STEER_LIM) steer_c = -cfdl_pkg::STEER_LIM;
    skew_c = cfg.skew_angle;
    if (cfg.skew_angle > cfdl_pkg::SKEW_LIM)  skew_c = cfdl_pkg::SKEW_LIM;
    if (cfg.skew_angle < -cfdl_pkg::SKEW_LIM) skew_c = -cfdl_pkg::SKEW_LIM;
  end

  assign c_start = (st_r == S_COS_A) || (st_r == S_COS_O);
  assign c_angle = (st_r == S_COS_O) ? skew_c : steer_c;

  cfdl_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .angle (c_angle),
    .done  (c_done),
    .cos_o (c_cos),
    .sin_o (c_sin)
  );

  // Offsets to the focal point
  assign dx = {fpx_r[20], fpx_r} - {{2{ex_r[19]}}, ex_r};
  assign dy = {fpy_r[20], fpy_r} - {{2{ey_r[19]}}, ey_r};
  assign dz = {fpz_r[20], fpz_r} - {{2{ez_r[19]}}, ez_r};

  // Multiplier operand select
  always_comb begin
    ma = ca_r;
    mb = $signed({2'b0, fe_r});
    case (mstep_r)
      M_FX: begin ma = ca_r; mb = $signed({2'b0, fe_r}); end
      M_T:  begin ma = sa_r; mb = $signed({2'b0, fe_r}); end
      M_FY: begin ma = co_r; mb = {t_r[20], t_r}; end
      M_FZ: begin ma = so_r; mb = {t_r[20], t_r}; end
      M_DX: begin ma = {{10{dx[21]}}, dx}; mb = dx; end
      M_DY: begin ma = {{10{dy[21]}}, dy}; mb = dy; end
      M_DZ: begin ma = {{10{dz[21]}}, dz}; mb = dz; end
      M_DLY: begin
        ma = $signed({11'b0, 21'(max_r - rd_r)});
        mb = $signed(cfdl_pkg::NS_SCALE);
      end
      default: begin ma = ca_r; mb = $signed({2'b0, fe_r}); end
    endcase
  end

  // Q30 rounding and focal clamp
  always_comb begin
    rsum   = prod_r + 54'sd536870912;
    rnd    = rsum[53:30];
    rclamp = rnd[20:0];
    if (rnd > $signed({4'b0, cfdl_pkg::FOCAL_MAX}))
      rclamp = $signed({1'b0, cfdl_pkg::FOCAL_MAX});
    if (rnd < -$signed({4'b0, cfdl_pkg::FOCAL_MAX}))
      rclamp = -$signed({1'b0, cfdl_pkg::FOCAL_MAX});
  end

  // Square root step
  assign sq_sum = sqr_r + sqb_r;
  assign sq_ge  = (sqn_r >= sq_sum);
  assign dist_w = (sqr_r > {25'b0, cfdl_pkg::DIST_MAX}) ? cfdl_pkg::DIST_MAX
                                                         : sqr_r[20:0];

  // Divider: depth conversion or delay scaling
  assign vel     = (cfg.plate_velocity == '0) ? 15'd1 : cfg.plate_velocity;
  assign d_start = ((st_r == S_FE) && cfg.focus_is_depth && !ca_r[31] && (ca_r != '0)) ||
                   ((st_r == S_MUL_WB) && (mstep_r == M_DLY));
  assign d_num   = (st_r == S_FE) ? {cfg.focal_length, 30'b0} : prod_r[48:0];
  assign d_den   = (st_r == S_FE) ? ca_r[30:0] : {16'b0, vel};
  assign sat     = |d_quo[48:24];

  cfdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d_start),
    .num   (d_num),
    .den   (d_den),
    .done  (d_done),
    .quo   (d_quo)
  );

  // Distance store write and registered read
  assign we = (st_r == S_STORE);
  always_ff @(posedge clk) begin
    if (we) begin
      dmem[cnt_r[cfdl_pkg::IDX_W-1:0]] <= dist_w;
    end
    rd_r <= dmem[k_r[cfdl_pkg::IDX_W-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      mstep_r   <= M_FX;
      cnt_r     <= '0;
      k_r       <= '0;
      max_r     <= '0;
      fpx_r     <= '0;
      fpy_r     <= '0;
      fpz_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            ex_r  <= q_item.item.elem_x;
            ey_r  <= q_item.item.elem_y;
            ez_r  <= q_item.item.elem_z;
            end_r <= q_item.end_law;
            if (q_item.first) begin
              cnt_r <= '0;
              max_r <= '0;
              st_r  <= S_COS_A;
            end else begin
              mstep_r <= M_DX;
              st_r    <= S_MUL;
            end
          end
        end
        S_COS_A: st_r <= S_WAIT_A;
        S_WAIT_A: begin
          if (c_done) begin
            ca_r <= c_cos;
            sa_r <= c_sin;
            st_r <= S_COS_O;
          end
        end
        S_COS_O: st_r <= S_WAIT_O;
        S_WAIT_O: begin
          if (c_done) begin
            co_r <= c_cos;
            so_r <= c_sin;
            st_r <= S_FE;
          end
        end
        S_FE: begin
          mstep_r <= M_FX;
          if (!cfg.focus_is_depth) begin
            fe_r <= {1'b0, cfg.focal_length};
            st_r <= S_MUL;
          end else if (ca_r[31] || (ca_r == '0)) begin
            fe_r <= cfdl_pkg::FOCAL_MAX;
            st_r <= S_MUL;
          end else begin
            st_r <= S_FE_WAIT;
          end
        end
        S_FE_WAIT: begin
          if (d_done) begin
            fe_r <= (|d_quo[48:20]) ? cfdl_pkg::FOCAL_MAX : d_quo[19:0];
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= ma * mb;
          st_r   <= S_MUL_WB;
        end
        S_MUL_WB: begin
          st_r <= S_MUL;
          case (mstep_r)
            M_FX: begin fpx_r <= rclamp;    mstep_r <= M_T;  end
            M_T:  begin t_r   <= rnd[20:0]; mstep_r <= M_FY; end
            M_FY: begin fpy_r <= rclamp;    mstep_r <= M_FZ; end
            M_FZ: begin fpz_r <= rclamp;    mstep_r <= M_DX; end
            M_DX: begin acc_r <= prod_r[44:0]; mstep_r <= M_DY; end
            M_DY: begin acc_r <= acc_r + prod_r[44:0]; mstep_r <= M_DZ; end
            M_DZ: begin
              sqn_r <= {1'b0, acc_r + prod_r[44:0]};
              sqr_r <= '0;
              sqb_r <= 46'h1 << 44;
              sqi_r <= '0;
              st_r  <= S_SQRT;
            end
            M_DLY: st_r <= S_DIV_WAIT;
            default: st_r <= S_IDLE;
          endcase
        end
        S_SQRT: begin
          if (sq_ge) begin
            sqn_r <= sqn_r - sq_sum;
            sqr_r <= (sqr_r >> 1) + sqb_r;
          end else begin
            sqr_r <= sqr_r >> 1;
          end
          sqb_r <= sqb_r >> 2;
          sqi_r <= sqi_r + 5'd1;
          if (sqi_r == 5'd22) begin
            st_r <= S_STORE;
          end
        end
        S_STORE: begin
          if (dist_w > max_r) max_r <= dist_w;
          cnt_r <= cnt_r + 1'b1;
          if (end_r) begin
            k_r  <= '0;
            st_r <= S_RD;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_RD: begin
          mstep_r <= M_DLY;
          st_r    <= S_MUL;
        end
        S_DIV_WAIT: begin
          if (d_done) begin
            out_vld_r           <= 1'b1;
            out_r.element_delay <= sat ? cfdl_pkg::DELAY_MAX : d_quo[23:0];
            out_r.delay_saturated <= sat;
            out_r.last_delay    <= (k_r + 1'b1 == cnt_r);
            k_r                 <= k_r + 1'b1;
            if (k_r + 1'b1 == cnt_r) begin
              cnt_r <= '0;
              max_r <= '0;
              st_r  <= S_IDLE;
            end else begin
              st_r <= S_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.last_delay) |-> (k_r < cnt_r))
    else $error("delay emitted past stored element count");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.last_delay) |-> ((cnt_r == '0) && (max_r == '0)))
    else $error("law state not cleared after final delay");
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_STORE) |-> (cnt_r < cfdl_pkg::CNT_W'(cfdl_pkg::MAX_ELEMENTS)))
    else $error("distance store overflow");
`endif

endmodule

// File: tb/contact_focal_delay_law_top_tb.sv
// Contact focal delay law testbench: directed and random laws against a focal-law predictor.
module contact_focal_delay_law_top_tb;

  localparam int  N_RANDOM   = 450;
  localparam int  IDLE_GAP   = 250;    // first element with depth mode, plus one square root
  localparam int  LIMIT      = 1000000;
  localparam int  UNUSED_IDX = 7;      // register index with nothing behind it
  localparam longint FMAX    = 1048575;
  localparam longint DMAX    = 2097151;
  localparam longint QONE    = 64'sd1073741824;

  // Arctangent of 2^-i, 0.01 degree / 65536 units
  localparam longint ATAN_STEP[24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45};

  // Focal law predictor and store of pending delays
  class delay_law_scoreboard;
    bit [31:0] steer, skew, focal, depth, vel;
    longint unsigned dist_mem[cfdl_pkg::MAX_ELEMENTS];
    int        elem_cnt;
    longint unsigned dist_peak;
    longint    fx, fy, fz;
    cfdl_pkg::out_item_t pending_delays[$];
    int        errors, n_results, n_sat, n_laws;

    function new();
      steer = 0; skew = 0; focal = 50000; depth = 0; vel = 5940;
      elem_cnt = 0; dist_peak = 0; fx = 0; fy = 0; fz = 0;
      errors = 0; n_results = 0; n_sat = 0; n_laws = 0;
    endfunction

    function void write_reg(int idx, bit [31:0] v);
      case (idx)
        cfdl_pkg::REG_STEER: steer = v & 32'h7FFF;
        cfdl_pkg::REG_SKEW:  skew  = v & 32'hFFFF;
        cfdl_pkg::REG_FOCAL: focal = v & 32'h7FFFF;
        cfdl_pkg::REG_DEPTH: depth = v & 32'h1;
        cfdl_pkg::REG_VEL:   vel   = v & 32'h7FFF;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint rnd_q30(longint p);
      return (p + (64'sd1 << 29)) >>> 30;
    endfunction

    // CORDIC sine/cosine in Q30, skew beyond +-90 degrees folded
    function void trig(longint cdeg, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      flip = 0;
      if (cdeg > 9000) begin
        cdeg -= 18000; flip = 1;
      end else if (cdeg < -9000) begin
        cdeg += 18000; flip = 1;
      end
      x = 652032874; y = 0; z = cdeg * 65536;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_STEP[i];
        end else begin
          x += dx; y -= dy; z += ATAN_STEP[i];
        end
      end
      x = clip(x, -QONE, QONE);
      y = clip(y, -QONE, QONE);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else
          r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void latch_focal_point();
      longint ca, sa, co, so, fe, t, st, sk;
      st = clip(longint'($signed(steer[14:0])), -9000, 9000);
      sk = clip(longint'($signed(skew[15:0])), -18000, 18000);
      trig(st, ca, sa);
      trig(sk, co, so);
      fe = focal;
      if (depth[0]) begin
        if (ca <= 0) fe = FMAX;
        else begin
          fe = (fe << 30) / ca;
          if (fe > FMAX) fe = FMAX;
        end
      end
      t  = rnd_q30(sa * fe);
      fx = clip(rnd_q30(ca * fe), -FMAX, FMAX);
      fy = clip(rnd_q30(co * t), -FMAX, FMAX);
      fz = clip(rnd_q30(so * t), -FMAX, FMAX);
    endfunction

    // Accepted element: store its distance, emit delays when the law ends
    function void note_element(cfdl_pkg::in_item_t it);
      longint dx, dy, dz;
      longint unsigned d, v, q;
      cfdl_pkg::out_item_t r;
      if (elem_cnt >= cfdl_pkg::MAX_ELEMENTS) elem_cnt = 0;
      if (elem_cnt == 0) begin
        latch_focal_point();
        dist_peak = 0;
      end
      dx = fx - longint'($signed(it.elem_x));
      dy = fy - longint'($signed(it.elem_y));
      dz = fz - longint'($signed(it.elem_z));
      d = int_sqrt(dx * dx + dy * dy + dz * dz);
      if (d > DMAX) d = DMAX;
      dist_mem[elem_cnt] = d;
      if (d > dist_peak) dist_peak = d;
      elem_cnt++;
      if (!it.last_element && elem_cnt < cfdl_pkg::MAX_ELEMENTS) return;
      v = (vel == 0) ? 1 : vel;
      for (int k = 0; k < elem_cnt; k++) begin
        q = (dist_peak - dist_mem[k]) * 1000 / v;
        r.delay_saturated = q > 64'd16777215;
        r.element_delay   = r.delay_saturated ? 24'hFFFFFF : q[23:0];
        r.last_delay      = (k + 1 == elem_cnt);
        pending_delays.push_back(r);
      end
      elem_cnt = 0;
      dist_peak = 0;
      n_laws++;
    endfunction

    function void check_delay(cfdl_pkg::out_item_t got, realtime t);
      cfdl_pkg::out_item_t exp_r;
      n_results++;
      if (got.delay_saturated) n_sat++;
      if (pending_delays.size() == 0) begin
        $display("%0t: unexpected delay %0d sat %0b last %0b", t,
                 got.element_delay, got.delay_saturated, got.last_delay);
        errors++;
        return;
      end
      exp_r = pending_delays.pop_front();
      if (got.element_delay !== exp_r.element_delay) begin
        $display("%0t: element_delay expected %0d actual %0d", t,
                 exp_r.element_delay, got.element_delay);
        errors++;
      end
      if (got.delay_saturated !== exp_r.delay_saturated) begin
        $display("%0t: delay_saturated expected %0b actual %0b", t,
                 exp_r.delay_saturated, got.delay_saturated);
        errors++;
      end
      if (got.last_delay !== exp_r.last_delay) begin
        $display("%0t: last_delay expected %0b actual %0b", t,
                 exp_r.last_delay, got.last_delay);
        errors++;
      end
    endfunction
  endclass

  logic                clk, rst_n, start, busy, out_strobe;
  cfdl_pkg::in_item_t  in_data;
  cfdl_pkg::out_item_t out_data;
  logic                psel, penable, pwrite, pready;
  logic [4:0]          paddr;
  logic [31:0]         pwdata, prdata;

  delay_law_scoreboard sb;
  int cycles;
  int n_items;
  int burst_left;

  contact_focal_delay_law_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_delay(out_data, $realtime);
  end

  task automatic reg_write(int idx, bit [31:0] v);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = 5'(idx * 4); pwdata = v;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Drive one item and hold it until accepted; start stays high afterwards
  task automatic send_element(logic signed [19:0] x, logic signed [19:0] y,
                              logic signed [19:0] z, logic last);
    cfdl_pkg::in_item_t it;
    it.elem_x = x; it.elem_y = y; it.elem_z = z; it.last_element = last;
    @(negedge clk);
    in_data = it;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_element(it);
    n_items++;
  endtask

  // Random element with burst/gap pacing on the sender
  task automatic paced_element(logic last);
    if (burst_left == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    send_element(20'($urandom), 20'($urandom), 20'($urandom), last);
  endtask

  // Stop sending until nothing is pending and the block has settled
  task automatic drain();
    @(negedge clk);
    start = 0;
    while (sb.pending_delays.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 3);
    reg_write(cfdl_pkg::REG_STEER,
              pick == 0 ? 32'($urandom_range(0, 1) ? 9000 : -9000)
              : pick == 1 ? $urandom : 32'($signed($urandom_range(0, 18000)) - 9000));
    reg_write(cfdl_pkg::REG_SKEW,
              pick == 0 ? 32'($urandom_range(0, 1) ? 18000 : -18000)
              : pick == 1 ? $urandom : 32'($signed($urandom_range(0, 36000)) - 18000));
    reg_write(cfdl_pkg::REG_FOCAL,
              pick == 0 ? 32'($urandom_range(0, 1) ? 500000 : 0)
              : pick == 1 ? $urandom : 32'($urandom_range(0, 500000)));
    reg_write(cfdl_pkg::REG_DEPTH, $urandom);
    reg_write(cfdl_pkg::REG_VEL,
              pick == 0 ? 32'($urandom_range(0, 1) ? 20000 : 100)
              : pick == 1 ? $urandom_range(0, 40) : 32'($urandom_range(100, 20000)));
  endtask

  initial begin
    int law_len;
    sb = new();
    cycles = 0; n_items = 0; burst_left = 0;
    rst_n = 0; start = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset settings, coordinate extremes
    send_element(20'sd0, 20'sd0, 20'sd0, 0);
    send_element(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 0);
    send_element(20'h80000, 20'h80000, 20'h80000, 0);
    send_element(20'sd500000, -20'sd500000, 20'sd1, 1);
    send_element(20'sd1234, 20'sd0, 20'sd0, 1);    // single element law
    drain();

    // Register written in the middle of a law: applies from the next law
    send_element(20'sd1000, 20'sd2000, 20'sd0, 0);
    drain();
    reg_write(cfdl_pkg::REG_STEER, 32'd3000);
    reg_write(UNUSED_IDX, 32'hFFFF_FFFF);
    send_element(-20'sd1000, 20'sd0, 20'sd0, 1);
    send_element(-20'sd1000, 20'sd0, 20'sd0, 1);
    drain();

    // Angles out of range, obliquity folded, depth at ninety degrees
    reg_write(cfdl_pkg::REG_STEER, 32'h3FFF);
    reg_write(cfdl_pkg::REG_SKEW, 32'h7FFF);
    reg_write(cfdl_pkg::REG_DEPTH, 32'd1);
    reg_write(cfdl_pkg::REG_FOCAL, 32'h7FFFF);
    send_element(20'sd0, 20'sd0, 20'sd0, 0);
    send_element(20'h80000, 20'h7FFFF, 20'h80000, 1);
    drain();
    reg_write(cfdl_pkg::REG_STEER, -32'sd9000);
    reg_write(cfdl_pkg::REG_SKEW, -32'sd17000);
    reg_write(cfdl_pkg::REG_VEL, 32'd0);          // zero velocity, saturating delays
    send_element(20'sd0, 20'sd0, 20'sd0, 0);
    send_element(20'sd400000, 20'sd400000, -20'sd400000, 0);
    send_element(20'sd300, -20'sd300, 20'sd300, 1);
    drain();
    reg_write(cfdl_pkg::REG_VEL, 32'd20000);
    reg_write(cfdl_pkg::REG_DEPTH, 32'd0);
    send_element(20'sd5, 20'sd5, 20'sd5, 0);
    send_element(-20'sd5, 20'sd5, 20'sd5, 1);
    drain();

    // Random laws; now and then a full store ends a law with no last flag
    while (n_items < N_RANDOM) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        random_config();
      end
      law_len = ($urandom_range(0, 15) == 0) ? cfdl_pkg::MAX_ELEMENTS
                                             : $urandom_range(1, 8);
      for (int i = 0; i < law_len; i++)
        paced_element(law_len < cfdl_pkg::MAX_ELEMENTS && i == law_len - 1);
    end

    @(negedge clk);
    start = 0;
    while (sb.pending_delays.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    $display("Covered %0d elements in %0d laws, %0d delays checked, %0d saturated.",
             n_items, sb.n_laws, sb.n_results, sb.n_sat);
    if (sb.errors == 0 && sb.pending_delays.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
